>>> hdl/kcl_pkg.sv
// Package for the 4x4 keypad code lock: constants, control-state type and key decode.
// No dependencies; imported by keypad_code_lock.
package kcl_pkg;

  // Widths of the lock's data
  localparam int CODE_W   = 64;
  localparam int DELAY_W  = 16;
  localparam int KEYS_W   = 16;
  localparam int COL_W    = 2;
  localparam int ROWS_W   = 4;
  localparam int DIGIT_W  = 4;

  // Reset values
  localparam logic [CODE_W-1:0]  DEFAULT_CODE  = 64'd63340500060;
  localparam logic [DELAY_W-1:0] DEFAULT_DELAY = 16'd100;

  // Key positions in the key map (row + 4 * column)
  localparam int KEY_CLEAR  = 3;
  localparam int KEY_BACK   = 7;
  localparam int KEY_CHANGE = 12;
  localparam int KEY_OK     = 15;

  // Item kinds carried on in_tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // Divide-by-ten unit: sixteen dividend bits per cycle by reciprocal multiply
  localparam int DIV_CHUNK   = 16;
  localparam int DIV_STEPS   = CODE_W / DIV_CHUNK;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int DIV_NUM_W   = DIV_CHUNK + DIGIT_W;
  localparam int DIV_PROD_W  = 2 * DIV_NUM_W;
  localparam int RECIP_SHIFT = 23;
  // ceil(2^23 / 10): exact quotient for any partial dividend below 2^22
  localparam logic [DIV_NUM_W-1:0] RECIP_TEN = 20'd838861;

  // Control state
  typedef enum logic {
    ST_RUN,
    ST_DIV
  } lock_state_t;

  // Result of the digit search
  typedef struct packed {
    logic                found;
    logic [DIGIT_W-1:0]  digit;
  } digit_hit_t;

  // Digit value of a key position; found is low for non-digit keys
  function automatic digit_hit_t key_digit(input logic [3:0] pos);
    digit_hit_t h;
    h.found = 1'b1;
    h.digit = '0;
    case (pos)
      4'd0:    h.digit = 4'd7;
      4'd1:    h.digit = 4'd8;
      4'd2:    h.digit = 4'd9;
      4'd4:    h.digit = 4'd4;
      4'd5:    h.digit = 4'd5;
      4'd6:    h.digit = 4'd6;
      4'd8:    h.digit = 4'd1;
      4'd9:    h.digit = 4'd2;
      4'd10:   h.digit = 4'd3;
      4'd13:   h.digit = 4'd0;
      default: h.found = 1'b0;
    endcase
    return h;
  endfunction

  // Lowest held digit key in the map
  function automatic digit_hit_t lowest_digit(input logic [KEYS_W-1:0] keys);
    digit_hit_t res;
    digit_hit_t h;
    res = '0;
    for (int b = KEYS_W - 1; b >= 0; b--) begin
      h = key_digit(4'(b));
      if (keys[b] && h.found) begin
        res = h;
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/keypad_code_lock.sv
// Top level of the 4x4 keypad code lock: key map, delay counter, code entry and compare.
// Depends on kcl_pkg.
//
//  channel  | direction | tdata (low bit up)                               | tuser
//  ---------+-----------+--------------------------------------------------+-------------
//  in_      | slave     | row_levels[3:0], zero pad to 8 bits              | cmd (0 tick)
//  out_     | master    | active_column[1:0], unlock, pressed_keys[15:0],  | -
//           |           | entered_code[63:0], zero pad to 88 bits          |
//  cfg_     | write     | digit_delay[15:0]                                | -
//
// One item per cycle when not stalled: each transfer is folded into the state in one pass
// and, unless it starts a divide, its result lands in the output register on the next edge.
// An item whose backspace acts on a non-zero code starts the divide-by-ten unit, which
// works through the 64-bit code sixteen bits a cycle, with in_tready low meanwhile.
// The output register stalls the input only when it is full and out_tready is low.
// rst_n (synchronous) restores the reset code, delay period 100 and an empty key map.
module keypad_code_lock
  import kcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // row_levels[3:0], pad
  input  logic        in_tuser,   // cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // active_column, unlock, pressed_keys, entered_code, pad
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // digit_delay
);

  // State
  lock_state_t         state_r, state_nxt;
  logic [DELAY_W-1:0]  digit_delay_r;
  logic [COL_W-1:0]    column_r, column_nxt;
  logic [KEYS_W-1:0]   key_map_r, key_map_nxt;
  logic                pending_r, pending_nxt;
  logic                ok_armed_r, ok_armed_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [CODE_W-1:0]   stored_r, stored_nxt;

  // Output register
  logic                out_valid_r;
  logic [COL_W-1:0]    out_col_r;
  logic                out_unlock_r;
  logic [KEYS_W-1:0]   out_keys_r;
  logic [CODE_W-1:0]   out_code_r;

  // Divider
  logic [CODE_W-1:0]   div_word_r, div_word_step;
  logic [DIGIT_W-1:0]  div_rem_r, div_rem_step;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                div_last;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_NUM_W-1:0]  div_back;
  logic [DIV_NUM_W-1:0]  div_diff;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [DIV_CHUNK-1:0]  div_q;

  // Item pass
  logic                in_xfer;
  logic [ROWS_W-1:0]   rows;
  logic                take_digit;
  digit_hit_t          hit;
  logic [CODE_W-1:0]   code_app;
  logic                unlock;
  logic [CODE_W-1:0]   code_clr;
  logic                pend_mid;
  logic                back_act;
  logic                div_start;
  logic                change_act;

  assign rows    = in_tdata[ROWS_W-1:0];
  assign in_xfer = in_tvalid && in_tready;

  // Single pass over one item
  always_comb begin
    column_nxt  = column_r;
    key_map_nxt = key_map_r;
    pending_nxt = pending_r;
    delay_nxt   = delay_r;
    if (in_tuser == CMD_TICK) begin
      delay_nxt = (delay_r >= digit_delay_r) ? '0 : delay_r + 1'b1;
    end else begin
      for (int r = 0; r < ROWS_W; r++) begin
        key_map_nxt[{column_r, 2'(r)}] = ~rows[r];
      end
      if (rows != '1) begin
        pending_nxt = 1'b1;
      end
      column_nxt = column_r + 1'b1;
    end

    // digit entry
    take_digit = pending_nxt && (delay_nxt == digit_delay_r);
    hit        = lowest_digit(key_map_nxt);
    code_app   = code_r;
    if (take_digit) begin
      if (hit.found) begin
        code_app = (code_r << 3) + (code_r << 1) + CODE_W'(hit.digit);
      end
      pending_nxt = 1'b0;
    end

    // OK arming and compare
    if (key_map_nxt[KEY_OK]) begin
      ok_armed_nxt = 1'b1;
    end else if (pending_nxt) begin
      ok_armed_nxt = 1'b0;
    end else begin
      ok_armed_nxt = ok_armed_r;
    end
    unlock = (code_app == stored_r) && ok_armed_nxt;

    // clear, backspace, change password
    code_clr = key_map_nxt[KEY_CLEAR] ? '0 : code_app;
    pend_mid = pending_nxt;
    back_act = key_map_nxt[KEY_BACK] && pend_mid;
    // a cleared code divides to zero, so the sequencer is only needed otherwise
    div_start = back_act && (code_clr != '0);
    if (back_act) begin
      pending_nxt = 1'b0;
    end
    change_act = key_map_nxt[KEY_CHANGE] && pending_nxt;
    stored_nxt = stored_r;
    code_nxt   = code_clr;
    if (change_act) begin
      stored_nxt  = code_clr;
      code_nxt    = '0;
      pending_nxt = 1'b0;
    end
  end

  // Long division by ten, sixteen dividend bits per step: the partial dividend is
  // below 10 * 2^16, so the reciprocal multiply gives its exact quotient
  always_comb begin
    div_num       = {div_rem_r, div_word_r[CODE_W-1 -: DIV_CHUNK]};
    div_prod      = DIV_PROD_W'(div_num) * DIV_PROD_W'(RECIP_TEN);
    div_q         = div_prod[RECIP_SHIFT +: DIV_CHUNK];
    div_back      = DIV_NUM_W'({div_q, 3'b000}) + DIV_NUM_W'({div_q, 1'b0});
    div_diff      = div_num - div_back;
    div_rem_step  = div_diff[DIGIT_W-1:0];
    div_word_step = {div_word_r[CODE_W-DIV_CHUNK-1:0], div_q};
  end

  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (in_xfer && div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // Handshake outputs
  always_comb begin
    case (state_r)
      ST_RUN:  in_tready = !out_valid_r || out_tready;
      ST_DIV:  in_tready = 1'b0;
      default: in_tready = 1'b0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_code_r, out_keys_r, out_unlock_r, out_col_r};

  // Control and lock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_RUN;
      digit_delay_r <= DEFAULT_DELAY;
      column_r      <= '0;
      key_map_r     <= '0;
      pending_r     <= 1'b0;
      ok_armed_r    <= 1'b0;
      delay_r       <= '0;
      code_r        <= '0;
      stored_r      <= DEFAULT_CODE;
      out_valid_r   <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        digit_delay_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        column_r   <= column_nxt;
        key_map_r  <= key_map_nxt;
        pending_r  <= pending_nxt;
        ok_armed_r <= ok_armed_nxt;
        delay_r    <= delay_nxt;
        stored_r   <= stored_nxt;
        if (!div_start) begin
          code_r <= code_nxt;
        end
        out_valid_r <= !div_start;
        div_cnt_r   <= '0;
      end else if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_last) begin
          code_r      <= div_word_step;
          out_valid_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and divider datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_col_r    <= column_nxt;
      out_unlock_r <= unlock;
      out_keys_r   <= key_map_nxt;
      out_code_r   <= code_nxt;
      div_word_r   <= code_clr;
      div_rem_r    <= '0;
    end else if (state_r == ST_DIV) begin
      div_word_r <= div_word_step;
      div_rem_r  <= div_rem_step;
      if (div_last) begin
        out_code_r <= div_word_step;
      end
    end
  end

endmodule

>>> test/keypad_code_lock_test.sv
// Self-checking testbench for keypad_code_lock: drives tick and scan transfers and checks
// every result against an in-bench model of the lock. Depends on kcl_pkg and keypad_code_lock.
`timescale 1ns / 100ps

module keypad_code_lock_test;
  import kcl_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 20;     // longer than a backspace divide
  localparam int LONG_HOLD     = 300;

  // One result as packed in out_tdata, lowest field last
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [KEYS_W-1:0] keys;
    logic              unlock;
    logic [COL_W-1:0]  column;
  } lock_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // row_levels[3:0], pad
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // active_column, unlock, pressed_keys, entered_code, pad
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // Lock model state
  logic [COL_W-1:0]   lock_col;
  logic [KEYS_W-1:0]  lock_keys;
  logic               lock_pending;
  logic               lock_ok;
  logic [DELAY_W-1:0] lock_count;
  logic [DELAY_W-1:0] lock_delay;
  logic [CODE_W-1:0]  lock_code;
  logic [CODE_W-1:0]  lock_stored;

  lock_result_t expected_results[$];

  int  cycle_count    = 0;
  int  error_count    = 0;
  int  items_sent     = 0;
  int  results_checked = 0;
  int  unlock_seen    = 0;
  bit  steady         = 1'b0;
  bit  long_hold_req  = 1'b0;

  keypad_code_lock dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  // Decimal value of a key position, -1 for keys that are not digits
  function automatic int key_digit_value(input int pos);
    case (pos)
      0:       return 7;
      1:       return 8;
      2:       return 9;
      4:       return 4;
      5:       return 5;
      6:       return 6;
      8:       return 1;
      9:       return 2;
      10:      return 3;
      13:      return 0;
      default: return -1;
    endcase
  endfunction

  // Key position of decimal digit n
  function automatic int digit_position(input int n);
    case (n)
      0:       return 13;
      1:       return 8;
      2:       return 9;
      3:       return 10;
      4:       return 4;
      5:       return 5;
      6:       return 6;
      7:       return 0;
      8:       return 1;
      default: return 2;
    endcase
  endfunction

  // Fold one accepted transfer into the lock state and return the result it gives
  function automatic lock_result_t predict_lock(input logic cmd, input logic [ROWS_W-1:0] rows);
    lock_result_t res;
    int           pos;
    int           value;
    logic         taken;
    logic         unlock_now;
    if (cmd == CMD_TICK) begin
      if (lock_count >= lock_delay) lock_count = '0;
      else lock_count = lock_count + 16'd1;
    end else begin
      for (int r = 0; r < ROWS_W; r++) begin
        pos = r + 4 * int'(lock_col);
        if (!rows[r]) begin
          lock_keys[pos] = 1'b1;
          lock_pending   = 1'b1;
        end else begin
          lock_keys[pos] = 1'b0;
        end
      end
      lock_col = lock_col + 2'd1;
    end
    // digit entry: lowest held digit key
    if (lock_pending && lock_count == lock_delay) begin
      taken = 1'b0;
      for (int b = 0; b < KEYS_W; b++) begin
        value = key_digit_value(b);
        if (!taken && lock_keys[b] && value >= 0) begin
          lock_code = lock_code * 64'd10 + 64'(value);
          taken     = 1'b1;
        end
      end
      lock_pending = 1'b0;
    end
    if (lock_keys[KEY_OK]) lock_ok = 1'b1;
    else if (lock_pending) lock_ok = 1'b0;
    // compare happens before clear, backspace and change act
    unlock_now = (lock_code == lock_stored) && lock_ok;
    if (lock_keys[KEY_CLEAR]) lock_code = '0;
    if (lock_keys[KEY_BACK] && lock_pending) begin
      lock_code    = lock_code / 64'd10;
      lock_pending = 1'b0;
    end
    if (lock_keys[KEY_CHANGE] && lock_pending) begin
      lock_stored  = lock_code;
      lock_code    = '0;
      lock_pending = 1'b0;
    end
    res.column = lock_col;
    res.unlock = unlock_now;
    res.keys   = lock_keys;
    res.code   = lock_code;
    return res;
  endfunction

  // Random key set for one stroke
  function automatic logic [KEYS_W-1:0] pick_keys(input bit digits_only);
    int                roll;
    logic [KEYS_W-1:0] held;
    roll = $urandom_range(0, 99);
    held = 16'(1) << digit_position($urandom_range(0, 9));
    if (digits_only) begin
      if (roll >= 95) held = 16'(1) << KEY_OK;
      else if (roll >= 90) held = 16'(1) << KEY_BACK;
    end else if (roll >= 92) begin
      held = 16'($urandom);
    end else if (roll >= 82) begin
      held = held | (16'(1) << $urandom_range(0, 15));
    end else if (roll >= 74) begin
      held = 16'(1) << KEY_OK;
    end else if (roll >= 66) begin
      held = 16'(1) << KEY_CHANGE;
    end else if (roll >= 58) begin
      held = 16'(1) << KEY_BACK;
    end else if (roll >= 52) begin
      held = 16'(1) << KEY_CLEAR;
    end
    return held;
  endfunction

  // Send one transfer, with an occasional gap first
  task automatic send_item(input logic cmd, input logic [ROWS_W-1:0] rows);
    if (!steady && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, rows};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_lock(cmd, rows));
    items_sent++;
  endtask

  // Stop sending and wait until every result is back and the lock is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] period);
    drain();
    cfg_wr_data <= period;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    lock_delay  = period;
  endtask

  // One full round of the four columns with the given keys down, stray ticks mixed in
  task automatic scan_frame(input logic [KEYS_W-1:0] held);
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(0, 9) == 0) send_item(CMD_TICK, 4'($urandom));
      send_item(CMD_SCAN, ~held[4 * int'(lock_col) +: 4]);
    end
  endtask

  // Press, wait some ticks, sometimes hold for another round, release
  task automatic key_stroke(input logic [KEYS_W-1:0] held, input int max_ticks);
    scan_frame(held);
    repeat ($urandom_range(0, max_ticks)) send_item(CMD_TICK, 4'($urandom));
    if ($urandom_range(0, 4) == 0) scan_frame(held);
    scan_frame('0);
  endtask

  // Mostly key strokes, some noise transfers
  task automatic run_phase(input int n_items, input bit digits_only);
    int stop;
    int max_ticks;
    stop      = items_sent + n_items;
    max_ticks = (lock_delay > 200) ? 8 : int'(lock_delay) + 2;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), 4'($urandom));
      end else begin
        key_stroke(pick_keys(digits_only), max_ticks);
      end
    end
  endtask

  // All keys at once under the reset period, ticks carrying row noise
  task automatic test_all_keys_at_reset_delay();
    repeat (4) send_item(CMD_SCAN, 4'h0);
    send_item(CMD_TICK, 4'h0);
    send_item(CMD_TICK, 4'hF);
    repeat (4) send_item(CMD_SCAN, 4'hF);
  endtask

  // Change password on an empty code, OK, a digit, backspace and clear with period 1
  task automatic test_lock_sequence();
    write_delay(16'd1);
    send_item(CMD_TICK, 4'h5);   // counter above period wraps to zero
    send_item(CMD_SCAN, 4'hF);
    send_item(CMD_SCAN, 4'hF);
    send_item(CMD_SCAN, 4'hF);
    send_item(CMD_SCAN, 4'hE);   // change password: stored code becomes zero
    send_item(CMD_SCAN, 4'hF);
    send_item(CMD_SCAN, 4'hF);
    send_item(CMD_SCAN, 4'hF);
    send_item(CMD_SCAN, 4'h7);   // OK down: lock opens
    send_item(CMD_SCAN, 4'hB);   // 9 down
    send_item(CMD_TICK, 4'h0);   // period reached: 9 entered
    send_item(CMD_TICK, 4'hF);
    send_item(CMD_SCAN, 4'h7);   // backspace
    send_item(CMD_SCAN, 4'hF);
    send_item(CMD_SCAN, 4'hF);   // OK released, stays armed
    send_item(CMD_SCAN, 4'h0);   // 7 8 9 and clear down, backspace still held takes the press
    send_item(CMD_TICK, 4'hA);   // period reached with nothing pending: no digit
  endtask

  task automatic test_zero_delay();
    write_delay(16'd0);
    run_phase(250, 1'b0);
  endtask

  // Digit, OK and backspace keys only: the code grows past 2^64 and wraps
  task automatic test_long_codes();
    write_delay(16'd1);
    run_phase(350, 1'b1);
  endtask

  task automatic test_short_delays();
    write_delay(16'd2);
    run_phase(200, 1'b0);
    write_delay(16'($urandom_range(3, 7)));
    run_phase(200, 1'b0);
  endtask

  task automatic test_default_delay();
    write_delay(DEFAULT_DELAY);
    run_phase(200, 1'b0);
  endtask

  task automatic test_max_delay();
    write_delay(16'hFFFF);
    run_phase(60, 1'b0);
  endtask

  // Receiver holds off while transfers keep coming, then the sender waits for all results
  task automatic test_backpressure();
    write_delay(16'd2);
    long_hold_req = 1'b1;
    run_phase(80, 1'b0);
    drain();
  endtask

  task automatic test_steady_stream();
    write_delay(16'd1);
    steady = 1'b1;
    run_phase(400, 1'b0);
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    lock_result_t want;
    lock_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(lock_result_t)-1:0];
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %h", got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.unlock) unlock_seen++;
        if (got.column !== want.column) begin
          $error("active_column: expected %0d, got %0d", want.column, got.column);
          error_count++;
        end
        if (got.unlock !== want.unlock) begin
          $error("unlock: expected %0b, got %0b", want.unlock, got.unlock);
          error_count++;
        end
        if (got.keys !== want.keys) begin
          $error("pressed_keys: expected %h, got %h", want.keys, got.keys);
          error_count++;
        end
        if (got.code !== want.code) begin
          $error("entered_code: expected %0d, got %0d", want.code, got.code);
          error_count++;
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_TICK;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    lock_col     = '0;
    lock_keys    = '0;
    lock_pending = 1'b0;
    lock_ok      = 1'b0;
    lock_count   = '0;
    lock_delay   = DEFAULT_DELAY;
    lock_code    = '0;
    lock_stored  = DEFAULT_CODE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_all_keys_at_reset_delay();
    test_lock_sequence();
    test_zero_delay();
    test_long_codes();
    test_short_delays();
    test_default_delay();
    test_max_delay();
    test_backpressure();
    test_steady_stream();

    // wait for the tail, bounded
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end

    $display("Sent %0d tick and scan transfers, checked %0d results (%0d with unlock high),",
             items_sent, results_checked, unlock_seen);
    $display("over digit delays from 0 to 65535 with random stalls and a long hold-off.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/kcl_pkg.sv
hdl/keypad_code_lock.sv
test/keypad_code_lock_test.sv
